// ===== rtl/core/lbcm_pkg.sv =====
// Shared types, constants and palette for the label boundary colour mapper.
package lbcm_pkg;

  localparam int CellIdW   = 16;
  localparam int CellTypeW = 4;
  localparam int CfgW      = 11;
  localparam int HW        = 11;
  localparam int PalIdxW   = 4;
  localparam int QDepth    = 4;
  localparam int QIdxW     = 2;
  localparam int QCntW     = 3;

  localparam logic [HW-1:0] MinHeight = HW'(3);
  localparam logic [HW-1:0] MaxHeight = HW'(1024);
  localparam logic [HW-1:0] RstHeight = HW'(64);

  localparam logic [CellTypeW-1:0] MaxCellType = CellTypeW'(9);

  localparam logic [PalIdxW-1:0] PalWhite = PalIdxW'(0);
  localparam logic [PalIdxW-1:0] PalBlack = PalIdxW'(1);
  localparam logic [PalIdxW-1:0] PalGray  = PalIdxW'(10);

  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [CellIdW-1:0]   cell_id;
    logic [CellTypeW-1:0] cell_type;
  } lbcm_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_boundary;
    logic       frame_end;
  } lbcm_out_t;

  // one queued request result: palette entry plus flags
  typedef struct packed {
    logic [PalIdxW-1:0] pal_idx;
    logic               is_boundary;
    logic               frame_end;
  } lbcm_res_t;

  function automatic logic [23:0] palette_rgb(input logic [PalIdxW-1:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = {8'd255, 8'd255, 8'd255};
      4'd1:    rgb = {8'd0,   8'd0,   8'd0};
      4'd2:    rgb = {8'd255, 8'd0,   8'd0};
      4'd3:    rgb = {8'd0,   8'd255, 8'd0};
      4'd4:    rgb = {8'd0,   8'd0,   8'd255};
      4'd5:    rgb = {8'd255, 8'd255, 8'd0};
      4'd6:    rgb = {8'd0,   8'd255, 8'd255};
      4'd7:    rgb = {8'd255, 8'd0,   8'd255};
      4'd8:    rgb = {8'd255, 8'd153, 8'd51};
      4'd9:    rgb = {8'd153, 8'd51,  8'd255};
      default: rgb = {8'd128, 8'd128, 8'd128};
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/core/lbcm_front.sv =====
// Front end: raster counters, line buffers and boundary classification.
module lbcm_front import lbcm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int ID_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [((($clog2(MAX_WIDTH+1)) > CfgW) ? $clog2(MAX_WIDTH+1) : CfgW)-1:0] img_width,
  input  logic [HW-1:0]            img_height,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  lbcm_in_t                 req,
  input  logic [QCntW-1:0]         q_level,
  output logic                     push,
  output lbcm_res_t                push_data
);

  localparam int WW   = ($clog2(MAX_WIDTH+1) > CfgW) ? $clog2(MAX_WIDTH+1) : CfgW;
  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IdW  = (ID_BITS < CellIdW) ? ID_BITS : CellIdW;

  logic [ColW-1:0] col;
  logic [HW-1:0]   row;

  logic [WW:0]     w_x;
  logic [WW:0]     c_x;
  logic [ColW-1:0] c;
  logic [ColW-1:0] c_right;
  logic            at_row_end;
  logic            done_rows;
  logic            accept;
  logic            take_label;
  logic            take_flush;
  logic            eligible;

  logic                 b_label;
  logic                 b_push;
  logic                 b_flush;
  logic                 b_elig;
  logic                 b_row_end;
  logic [ColW-1:0]      b_col;
  logic [IdW-1:0]       b_new_id;
  logic [CellTypeW-1:0] b_new_type;

  logic [IdW-1:0]       left_id;

  logic [IdW-1:0]       upper_mem [MAX_WIDTH];
  logic [IdW-1:0]       mid_mem   [MAX_WIDTH];
  logic [CellTypeW-1:0] type_mem  [MAX_WIDTH];

  logic [IdW-1:0]       up_rd;
  logic [IdW-1:0]       mid_rd;
  logic [IdW-1:0]       right_rd;
  logic [CellTypeW-1:0] type_rd;

  logic                 boundary;
  logic [PalIdxW-1:0]   pal_idx;

  assign req_stall = ({1'b0, q_level} + {{QCntW{1'b0}}, b_push}) >= (QCntW+1)'(QDepth);
  assign accept    = req_valid & ~req_stall;

  always_comb begin
    w_x = {1'b0, img_width};
    c_x = (WW+1)'(col);
    if (c_x >= w_x) begin
      c_x = w_x - (WW+1)'(1);
    end
    c          = c_x[ColW-1:0];
    at_row_end = (c_x + (WW+1)'(1)) >= w_x;
    c_right    = at_row_end ? c : c + ColW'(1);
    done_rows  = row >= img_height;
    take_label = accept & ~req.req_type & ~done_rows;
    take_flush = accept & req.req_type & done_rows;
    eligible   = (row >= HW'(2)) && ((row + HW'(1)) <= img_height) &&
                 (c_x >= (WW+1)'(1)) && ((c_x + (WW+1)'(2)) <= w_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take_label) begin
      if (at_row_end) begin
        col <= '0;
        row <= row + HW'(1);
      end else begin
        col <= c + ColW'(1);
      end
    end else if (take_flush) begin
      if (at_row_end) begin
        col <= '0;
        row <= '0;
      end else begin
        col <= c + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_label <= 1'b0;
      b_push  <= 1'b0;
      b_flush <= 1'b0;
    end else begin
      b_label <= take_label;
      b_push  <= (take_label && (row != '0)) || take_flush;
      b_flush <= take_flush;
    end
  end

  always_ff @(posedge clk) begin
    b_elig     <= eligible & ~req.req_type;
    b_row_end  <= at_row_end;
    b_col      <= c;
    b_new_id   <= req.cell_id[IdW-1:0];
    b_new_type <= req.cell_type;
  end

  // line buffers: read every cycle, written back in the cycle after a label request is taken
  always_ff @(posedge clk) begin
    up_rd    <= upper_mem[c];
    mid_rd   <= mid_mem[c];
    right_rd <= mid_mem[c_right];
    type_rd  <= type_mem[c];
    if (b_label) begin
      upper_mem[b_col] <= mid_rd;
      mid_mem[b_col]   <= b_new_id;
      type_mem[b_col]  <= b_new_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_id <= '0;
    end else if (b_label) begin
      left_id <= b_row_end ? '0 : mid_rd;
    end else if (b_flush && b_row_end) begin
      left_id <= '0;
    end
  end

  always_comb begin
    boundary = b_elig && ((mid_rd != up_rd) || (mid_rd != b_new_id) ||
                          (mid_rd != left_id) || (mid_rd != right_rd));
    if (boundary) begin
      pal_idx = PalBlack;
    end else if (mid_rd == '0) begin
      pal_idx = PalWhite;
    end else if (type_rd > MaxCellType) begin
      pal_idx = PalGray;
    end else begin
      pal_idx = PalIdxW'(type_rd) + PalIdxW'(1);
    end
  end

  assign push                  = b_push;
  assign push_data.pal_idx     = pal_idx;
  assign push_data.is_boundary = boundary;
  assign push_data.frame_end   = b_flush & b_row_end;

endmodule

// ===== rtl/core/lbcm_queue.sv =====
// Short result queue between the front end and the output stage.
module lbcm_queue import lbcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lbcm_res_t        push_data,
  input  logic             pop,
  output logic             not_empty,
  output lbcm_res_t        head,
  output logic [QCntW-1:0] level
);

  lbcm_res_t        entries [QDepth];
  logic [QIdxW-1:0] wr_ptr;
  logic [QIdxW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QIdxW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QIdxW'(1);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;
  assign level     = count;

endmodule

// ===== rtl/core/lbcm_back.sv =====
// Back end: palette lookup into the output register.
module lbcm_back import lbcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  lbcm_res_t q_data,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output lbcm_out_t res
);

  logic load;

  assign load = q_valid & (~res_valid | ~res_stall);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      {res.red, res.green, res.blue} <= palette_rgb(q_data.pal_idx);
      res.is_boundary                <= q_data.is_boundary;
      res.frame_end                  <= q_data.frame_end;
    end
  end

endmodule

// ===== rtl/core/label_boundary_colour_mapper.sv =====
// Top level of the label boundary colour mapper.
//
// Requests arrive on req (req_valid/req_stall), one label pixel per request
// in raster order, followed by one flush request per column to drain the
// last row. Results leave on res (res_valid/res_stall), one coloured pixel
// per emitting request; the first row and ignored requests give none.
// Pixel (r, c) is emitted by the request of pixel (r+1, c), or by a flush.
// Throughput: one request per clock while req_stall is low, limited by the
// single write port of each line buffer. Path: line buffer read registers,
// combinational classification, queue, output register. A stalled res holds
// its value; results back up into a four-entry queue and req_stall rises
// once the queue cannot take more. cfg_wen/cfg_index/cfg_data set image
// width and height; write them only while no request is in flight. Reset
// clears counters, queue and output valid and sets both sizes to 64 (the
// width at most MAX_WIDTH); the line buffers are not cleared.
module label_boundary_colour_mapper import lbcm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int ID_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wen,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  lbcm_in_t        req,
  output logic            res_valid,
  input  logic            res_stall,
  output lbcm_out_t       res
);

  localparam int WW = ($clog2(MAX_WIDTH+1) > CfgW) ? $clog2(MAX_WIDTH+1) : CfgW;
  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] RstW = (MAX_WIDTH < 64) ? WW'(MAX_WIDTH) : WW'(64);

  logic [WW-1:0]    img_width;
  logic [HW-1:0]    img_height;
  logic [WW-1:0]    width_next;
  logic [HW-1:0]    height_next;
  logic [WW-1:0]    data_w;

  logic             push;
  lbcm_res_t        push_data;
  logic             pop;
  logic             q_valid;
  lbcm_res_t        q_head;
  logic [QCntW-1:0] q_level;

  // sizes are held already clamped
  always_comb begin
    data_w = WW'(cfg_data);
    if (data_w < WW'(3)) begin
      width_next = WW'(3);
    end else if (data_w > MaxW) begin
      width_next = MaxW;
    end else begin
      width_next = data_w;
    end
    if (cfg_data < MinHeight) begin
      height_next = MinHeight;
    end else if (cfg_data > MaxHeight) begin
      height_next = MaxHeight;
    end else begin
      height_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= RstW;
      img_height <= RstHeight;
    end else if (cfg_wen) begin
      case (cfg_index)
        RegImageWidth:  img_width  <= width_next;
        RegImageHeight: img_height <= height_next;
        default: ;
      endcase
    end
  end

  lbcm_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .img_width  (img_width),
    .img_height (img_height),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .q_level    (q_level),
    .push       (push),
    .push_data  (push_data)
  );

  lbcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head),
    .level     (q_level)
  );

  lbcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
